// ----- rtl/pmst_pkg.sv -----
package pmst_pkg;

   // fixed field widths of the stream ports
   localparam int NODE_W     = 6;
   localparam int WEIGHT_W   = 16;
   localparam int COUNT_W    = 7;
   localparam int DATA_W     = 32;

   // node_count after reset
   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd32;

   // per-cycle commands from the sequencer to the node store
   typedef struct packed {
      logic scan_rd;    // read node entry and relax it next cycle
      logic emit_rd;    // read node entry for result output
      logic first;      // first round: entry content taken as run start value
      logic best_clr;   // restart the minimum search
   } pmst_ctrl_type;

endpackage

// ----- rtl/prim_mst_dense_matrix.sv -----
// Dense Prim minimum spanning tree. Matrix entries (row, col, weight) stream in on req_, one
// transaction per cycle while loading; weight 0 means no edge, entries with row or col of
// MAX_NODES or more are dropped. The transaction with tlast set is stored and, if node_count
// clamped to MAX_NODES is at least two, then starts a run from node 0 over the first count
// nodes. Each of the count-1 rounds scans the node store and the matrix row of the newest tree
// node, one node per cycle, then drains and picks the next tree node. Then one edge per node
// 1..count-1 leaves on rsp_ in node order after a node read and a weight read, held through any
// rsp_tready stall; tuser is clear for a node that was never reached, with parent and weight
// zero. No new matrix entry is taken until the last edge of a run has gone out. The user must
// write node_count through csr_ only while the block is idle; the block does not enforce it.
module prim_mst_dense_matrix #(
   parameter int MAX_NODES = 32,
   parameter int WEIGHT_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   // row [5:0], col [11:6], weight [27:12]
   input  logic [pmst_pkg::DATA_W-1:0]  req_tdata,
   input  logic                        req_tlast,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // parent_node [5:0], child_node [11:6], edge_weight [27:12]
   output logic [pmst_pkg::DATA_W-1:0]  rsp_tdata,
   // reached [0]
   output logic                        rsp_tuser,
   output logic                        rsp_tlast,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   input  logic [pmst_pkg::COUNT_W-1:0] csr_data,
   input  logic                        csr_valid,
   output logic                        csr_ready
);
   import pmst_pkg::*;

   localparam int IDX_W  = $clog2(MAX_NODES);
   localparam int CNT_W  = $clog2(MAX_NODES + 1);
   localparam int ADDR_W = 2 * IDX_W;
   localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_NODES);

   localparam logic [2:0] S_LOAD      = 3'd0;
   localparam logic [2:0] S_SCAN      = 3'd1;
   localparam logic [2:0] S_DRAIN     = 3'd2;
   localparam logic [2:0] S_PICK      = 3'd3;
   localparam logic [2:0] S_EMIT_NODE = 3'd4;
   localparam logic [2:0] S_EMIT_WT   = 3'd5;
   localparam logic [2:0] S_EMIT_OUT  = 3'd6;

   logic [2:0]             state_ff, state_in;
   logic [COUNT_W-1:0]     node_count_ff;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       v_ff, v_in;
   logic [CNT_W-1:0]       round_ff, round_in;
   logic [CNT_W-1:0]       k_ff, k_in;
   logic [IDX_W-1:0]       u_ff, u_in;
   logic                   first_ff, first_in;

   logic [WEIGHT_BITS-1:0] wt_mem [2**ADDR_W];
   logic [WEIGHT_BITS-1:0] wt_rd_ff;
   logic [ADDR_W-1:0]      wt_rd_addr;
   logic                   wt_rd_en;
   logic                   wt_wr_en;

   logic [NODE_W-1:0]      req_row;
   logic [NODE_W-1:0]      req_col;
   logic [WEIGHT_W-1:0]    req_weight;
   logic                   req_fire;
   logic [COUNT_W-1:0]     count_sat;

   pmst_ctrl_type          ctrl;
   logic [IDX_W-1:0]       node_rd_addr;
   logic [IDX_W-1:0]       best_idx;
   logic [IDX_W-1:0]       rd_parent;
   logic                   rd_parent_set;

   assign req_row    = req_tdata[5:0];
   assign req_col    = req_tdata[11:6];
   assign req_weight = req_tdata[27:12];
   assign req_tready = (state_ff == S_LOAD);
   assign req_fire   = req_tvalid && req_tready;
   assign count_sat  = (node_count_ff > MAX_CNT) ? MAX_CNT : node_count_ff;

   // configuration register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         node_count_ff <= csr_data;
      end
   end

   // weight matrix store
   assign wt_wr_en = req_fire && ({1'b0, req_row} < MAX_CNT) && ({1'b0, req_col} < MAX_CNT);
   assign wt_rd_en = (state_ff == S_SCAN) || (state_ff == S_EMIT_WT);
   assign wt_rd_addr = (state_ff == S_SCAN) ? {u_ff, v_ff[IDX_W-1:0]}
                                            : {rd_parent, k_ff[IDX_W-1:0]};

   always_ff @(posedge clock) begin
      if (wt_wr_en) begin
         wt_mem[{req_row[IDX_W-1:0], req_col[IDX_W-1:0]}] <= WEIGHT_BITS'(req_weight);
      end
      if (wt_rd_en) begin
         wt_rd_ff <= wt_mem[wt_rd_addr];
      end
   end

   // node store and minimum search
   assign node_rd_addr = (state_ff == S_SCAN) ? v_ff[IDX_W-1:0] : k_ff[IDX_W-1:0];

   pmst_scan #(
      .MAX_NODES   (MAX_NODES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .rd_addr       (node_rd_addr),
      .tree_node     (u_ff),
      .edge_wt       (wt_rd_ff),
      .best_idx      (best_idx),
      .rd_parent     (rd_parent),
      .rd_parent_set (rd_parent_set)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      v_in          = v_ff;
      round_in      = round_ff;
      k_in          = k_ff;
      u_in          = u_ff;
      first_in      = first_ff;
      ctrl.scan_rd  = 1'b0;
      ctrl.emit_rd  = 1'b0;
      ctrl.first    = first_ff;
      ctrl.best_clr = 1'b0;
      unique case (state_ff)
         S_LOAD: begin
            if (req_fire && req_tlast && (count_sat >= COUNT_W'(2))) begin
               count_in      = CNT_W'(count_sat);
               v_in          = '0;
               round_in      = '0;
               u_in          = '0;
               first_in      = 1'b1;
               ctrl.best_clr = 1'b1;
               state_in      = S_SCAN;
            end
         end
         S_SCAN: begin
            ctrl.scan_rd = 1'b1;
            v_in         = v_ff + CNT_W'(1);
            if (v_ff == count_ff - CNT_W'(1)) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            u_in          = best_idx;
            ctrl.best_clr = 1'b1;
            first_in      = 1'b0;
            round_in      = round_ff + CNT_W'(1);
            v_in          = '0;
            if (round_ff == count_ff - CNT_W'(2)) begin
               k_in     = CNT_W'(1);
               state_in = S_EMIT_NODE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_EMIT_NODE: begin
            ctrl.emit_rd = 1'b1;
            state_in     = S_EMIT_WT;
         end
         S_EMIT_WT: begin
            state_in = S_EMIT_OUT;
         end
         S_EMIT_OUT: begin
            if (rsp_tready) begin
               if (k_ff == count_ff - CNT_W'(1)) begin
                  state_in = S_LOAD;
               end else begin
                  k_in     = k_ff + CNT_W'(1);
                  state_in = S_EMIT_NODE;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         first_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         first_ff <= first_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      v_ff     <= v_in;
      round_ff <= round_in;
      k_ff     <= k_in;
      u_ff     <= u_in;
   end

   // result transaction, held from registered store outputs
   assign rsp_tvalid = (state_ff == S_EMIT_OUT);
   assign rsp_tuser  = rd_parent_set;
   assign rsp_tlast  = (k_ff == count_ff - CNT_W'(1));
   assign rsp_tdata  = {4'b0000,
                        rd_parent_set ? WEIGHT_W'(wt_rd_ff) : {WEIGHT_W{1'b0}},
                        NODE_W'(k_ff),
                        rd_parent_set ? NODE_W'(rd_parent) : {NODE_W{1'b0}}};

endmodule

// ----- rtl/pmst_scan.sv -----
module pmst_scan #(
   parameter int MAX_NODES = 32,
   parameter int WEIGHT_BITS = 16,
   localparam int IDX_W = $clog2(MAX_NODES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pmst_pkg::pmst_ctrl_type ctrl,
   input  logic [IDX_W-1:0]       rd_addr,
   input  logic [IDX_W-1:0]       tree_node,
   input  logic [WEIGHT_BITS-1:0] edge_wt,
   output logic [IDX_W-1:0]       best_idx,
   output logic [IDX_W-1:0]       rd_parent,
   output logic                   rd_parent_set
);
   import pmst_pkg::*;

   localparam int KEY_W = WEIGHT_BITS + 1;
   localparam int NW    = KEY_W + IDX_W + 2;
   localparam logic [KEY_W-1:0] KEY_INF = {1'b1, {WEIGHT_BITS{1'b0}}};

   // node entry: {in_tree, parent_set, parent, key}
   logic [NW-1:0]     node_mem [MAX_NODES];
   logic [NW-1:0]     rdata_ff;
   logic [NW-1:0]     wdata;
   logic              relax_vld_ff;
   logic              first_ff;
   logic [IDX_W-1:0]  v_ff;
   logic [KEY_W-1:0]  best_key_ff;
   logic [IDX_W-1:0]  best_idx_ff;

   logic [KEY_W-1:0]  old_key;
   logic [IDX_W-1:0]  old_parent;
   logic              old_pset;
   logic              old_in_tree;
   logic              is_u;
   logic              upd;
   logic [KEY_W-1:0]  new_key;
   logic [IDX_W-1:0]  new_parent;
   logic              new_pset;
   logic              new_in_tree;

   // node store, one read and one write port
   always_ff @(posedge clock) begin
      if (ctrl.scan_rd || ctrl.emit_rd) begin
         rdata_ff <= node_mem[rd_addr];
      end
      if (relax_vld_ff) begin
         node_mem[v_ff] <= wdata;
      end
   end

   // relax stage tracking
   always_ff @(posedge clock) begin
      if (reset) begin
         relax_vld_ff <= 1'b0;
      end else begin
         relax_vld_ff <= ctrl.scan_rd;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.scan_rd) begin
         v_ff     <= rd_addr;
         first_ff <= ctrl.first;
      end
   end

   // old entry, or run start values in the first round
   always_comb begin
      if (first_ff) begin
         old_key     = (v_ff == '0) ? '0 : KEY_INF;
         old_parent  = '0;
         old_pset    = 1'b0;
         old_in_tree = 1'b0;
      end else begin
         old_key     = rdata_ff[KEY_W-1:0];
         old_parent  = rdata_ff[KEY_W +: IDX_W];
         old_pset    = rdata_ff[KEY_W+IDX_W];
         old_in_tree = rdata_ff[KEY_W+IDX_W+1];
      end
   end

   // key relaxation against the edge from the newest tree node
   always_comb begin
      is_u        = (v_ff == tree_node);
      upd         = (edge_wt != '0) && !old_in_tree && !is_u && ({1'b0, edge_wt} < old_key);
      new_key     = upd ? {1'b0, edge_wt} : old_key;
      new_parent  = upd ? tree_node : old_parent;
      new_pset    = upd | old_pset;
      new_in_tree = old_in_tree | is_u;
      wdata       = {new_in_tree, new_pset, new_parent, new_key};
   end

   // running minimum for the next pick, lowest index wins ties
   always_ff @(posedge clock) begin
      if (ctrl.best_clr) begin
         best_key_ff <= KEY_INF;
         best_idx_ff <= '0;
      end else if (relax_vld_ff && !new_in_tree && (new_key < best_key_ff)) begin
         best_key_ff <= new_key;
         best_idx_ff <= v_ff;
      end
   end

   assign best_idx      = best_idx_ff;
   assign rd_parent     = rdata_ff[KEY_W +: IDX_W];
   assign rd_parent_set = rdata_ff[KEY_W+IDX_W];

endmodule

// ----- verif/tb_prim_mst_dense_matrix.sv -----
`timescale 1ns / 100ps

module tb_prim_mst_dense_matrix;
   import pmst_pkg::*;

   localparam int MAX_NODES     = 32;
   localparam int WEIGHT_BITS   = 16;
   localparam logic [WEIGHT_W:0] KEY_INF = 17'h10000;
   localparam int RANDOM_TARGET = 330;
   localparam int SETTLE_CYCLES = 1200;
   localparam int LONG_HOLD     = 800;
   localparam int STALL_LIMIT   = 16000;

   typedef struct {
      logic [NODE_W-1:0]   row;
      logic [NODE_W-1:0]   col;
      logic [WEIGHT_W-1:0] weight;
      logic                last;
   } matrix_entry_t;

   typedef struct {
      logic [NODE_W-1:0]   parent;
      logic [NODE_W-1:0]   child;
      logic [WEIGHT_W-1:0] weight;
      logic                reached;
      logic                last_edge;
   } tree_edge_t;

   logic                clock;
   logic                reset      = 1'b1;
   logic [DATA_W-1:0]   req_tdata  = '0;
   logic                req_tlast  = 1'b0;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [DATA_W-1:0]   rsp_tdata;
   logic                rsp_tuser;
   logic                rsp_tlast;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [COUNT_W-1:0]  csr_data   = '0;
   logic                csr_valid  = 1'b0;
   logic                csr_ready;

   // predictor state: matrix copy and node count shadow
   logic [WEIGHT_W-1:0] adj_weight [MAX_NODES][MAX_NODES];
   logic [COUNT_W-1:0]  node_count_model = COUNT_RESET;

   matrix_entry_t pending_entries[$];
   tree_edge_t    expected_edges[$];
   tree_edge_t    seen_edge;
   tree_edge_t    want_edge;

   // handshake between processes
   bit req_fired;
   bit hold_request;
   bit steady_flow;
   int req_gap;
   int rsp_gap;
   int hold_left;
   int stall_cycles;

   // run statistics
   int error_count;
   int queued_items;
   int run_count;
   int empty_runs;
   int edges_checked;
   int unreached_edges;
   int ignored_writes;

   prim_mst_dense_matrix #(
      .MAX_NODES   (MAX_NODES),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_data   (csr_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // dense prim over the shadow matrix, queues one edge per node 1..n-1
   task automatic predict_tree();
      int unsigned nodes;
      int unsigned pick;
      logic [WEIGHT_W:0] best;
      logic [WEIGHT_W:0] key [MAX_NODES];
      int unsigned parent [MAX_NODES];
      bit has_parent [MAX_NODES];
      bit joined [MAX_NODES];
      tree_edge_t result;
      nodes = (node_count_model > MAX_NODES) ? MAX_NODES : node_count_model;
      run_count++;
      if (nodes < 2) begin
         empty_runs++;
         return;
      end
      for (int i = 0; i < MAX_NODES; i++) begin
         key[i] = KEY_INF;
         parent[i] = 0;
         has_parent[i] = 1'b0;
         joined[i] = 1'b0;
      end
      key[0] = '0;
      for (int t = 0; t + 1 < nodes; t++) begin
         // lowest key outside the tree, lowest index wins ties, node 0 if none
         best = KEY_INF;
         pick = 0;
         for (int i = 0; i < nodes; i++) begin
            if (!joined[i] && key[i] < best) begin
               best = key[i];
               pick = i;
            end
         end
         joined[pick] = 1'b1;
         // strict less-than relaxation along the picked node's row
         for (int v = 0; v < nodes; v++) begin
            if (adj_weight[pick][v] != 0 && !joined[v] && {1'b0, adj_weight[pick][v]} < key[v])
            begin
               key[v] = {1'b0, adj_weight[pick][v]};
               parent[v] = pick;
               has_parent[v] = 1'b1;
            end
         end
      end
      for (int k = 1; k < nodes; k++) begin
         result.child = k;
         result.reached = has_parent[k];
         result.parent = has_parent[k] ? parent[k] : 0;
         result.weight = has_parent[k] ? adj_weight[parent[k]][k] : '0;
         result.last_edge = (k + 1 == nodes);
         expected_edges.push_back(result);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         error_count++;
      end
   endtask

   // input driver: next entry from the queue, random gaps between transactions outside steady flow
   always @(negedge clock) begin
      if (!req_tvalid || req_fired) begin
         req_fired = 1'b0;
         if (req_gap > 0) begin
            req_gap--;
            req_tvalid <= 1'b0;
         end else if (pending_entries.size() > 0) begin
            req_tdata <= {pending_entries[0].weight, pending_entries[0].col,
                          pending_entries[0].row};
            req_tlast <= pending_entries[0].last;
            req_tvalid <= 1'b1;
            if (!steady_flow && $urandom_range(0, 9) == 0)
               req_gap = $urandom_range(1, 8);
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // result ready: long hold on request, otherwise short random stalls outside steady flow
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_gap--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if (!steady_flow && $urandom_range(0, 7) == 0)
            rsp_gap = $urandom_range(1, 8);
      end
   end

   // monitor: model update on accepted transactions, edge compare, watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            seen_edge.parent = rsp_tdata[5:0];
            seen_edge.child = rsp_tdata[11:6];
            seen_edge.weight = rsp_tdata[27:12];
            seen_edge.reached = rsp_tuser;
            seen_edge.last_edge = rsp_tlast;
            if (expected_edges.size() == 0) begin
               $error("unexpected tree edge: parent %0d child %0d weight %0d",
                      seen_edge.parent, seen_edge.child, seen_edge.weight);
               error_count++;
            end else begin
               want_edge = expected_edges.pop_front();
               check_field("parent_node", want_edge.parent, seen_edge.parent);
               check_field("child_node", want_edge.child, seen_edge.child);
               check_field("edge_weight", want_edge.weight, seen_edge.weight);
               check_field("reached", want_edge.reached, seen_edge.reached);
               check_field("last_edge", want_edge.last_edge, seen_edge.last_edge);
               edges_checked++;
               if (!want_edge.reached)
                  unreached_edges++;
            end
         end
         if (csr_valid && csr_ready)
            node_count_model = csr_data;
         if (req_tvalid && req_tready) begin
            req_fired = 1'b1;
            void'(pending_entries.pop_front());
            if (req_tdata[5:0] < MAX_NODES && req_tdata[11:6] < MAX_NODES)
               adj_weight[req_tdata[5:0]][req_tdata[11:6]] = req_tdata[27:12];
            else
               ignored_writes++;
            if (req_tlast)
               predict_tree();
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
             (csr_valid && csr_ready))
            stall_cycles = 0;
         else
            stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $error("no transaction for %0d cycles, %0d edges still expected",
                   stall_cycles, expected_edges.size());
            $display("tb_prim_mst_dense_matrix: errors");
            $finish;
         end
      end
   end

   task automatic send_entry(input int row, input int col, input logic [WEIGHT_W-1:0] weight,
                             input bit last);
      matrix_entry_t ent;
      ent.row = row;
      ent.col = col;
      ent.weight = weight;
      ent.last = last;
      pending_entries.push_back(ent);
      if ((row < MAX_NODES && col < MAX_NODES) || last)
         queued_items++;
   endtask

   // mix of no edge, small tie-prone weights, full range and extremes
   function automatic logic [WEIGHT_W-1:0] random_weight();
      int unsigned pick;
      pick = $urandom_range(0, 19);
      if (pick < 5)
         return '0;
      else if (pick < 12)
         return $urandom_range(1, 6);
      else if (pick < 18)
         return $urandom_range(1, 16'hFFFF);
      else
         return (pick == 18) ? 16'hFFFF : 16'h8000;
   endfunction

   // drain everything, then give the block time to finish a result-free run
   task automatic wait_idle();
      do @(posedge clock);
      while (pending_entries.size() != 0 || req_tvalid || expected_edges.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_node_count(input logic [COUNT_W-1:0] value);
      wait_idle();
      @(negedge clock);
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock);
      while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // stimulus
   initial begin
      int unsigned span;
      int unsigned items;
      int unsigned runs;
      int unsigned cut_node;
      int unsigned phase;
      int unsigned random_base;
      logic [COUNT_W-1:0] count_val;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (3) @(posedge clock);

      // preload the whole matrix, run at the reset node count
      for (int r = 0; r < MAX_NODES; r++)
         for (int c = 0; c < MAX_NODES; c++)
            send_entry(r, c, random_weight(), (r == MAX_NODES - 1) && (c == MAX_NODES - 1));

      // two nodes: max weight, no edge, dropped writes outside the built size
      write_node_count(7'd2);
      send_entry(0, 1, 16'hFFFF, 0);
      send_entry(1, 0, 16'h0001, 1);
      send_entry(0, 1, 16'h0000, 1);
      send_entry(63, 63, 16'hFFFF, 1);
      send_entry(32, 0, 16'h1234, 0);
      send_entry(0, 32, 16'h4321, 0);
      send_entry(0, 1, 16'h5555, 0);
      send_entry(0, 1, 16'hAAAA, 1);

      // counts below two give no result
      write_node_count(7'd0);
      send_entry(0, 1, 16'h0007, 1);
      write_node_count(7'd1);
      send_entry(1, 1, 16'h0003, 1);

      // equal keys, lowest index must win
      write_node_count(7'd4);
      send_entry(0, 1, 16'd5, 0);
      send_entry(0, 2, 16'd5, 0);
      send_entry(0, 3, 16'd5, 0);
      send_entry(1, 2, 16'd5, 0);
      send_entry(1, 3, 16'd2, 0);
      send_entry(2, 3, 16'd0, 1);

      // counts above the built size saturate
      write_node_count(7'd127);
      send_entry(31, 0, 16'h8000, 1);
      write_node_count(7'd64);
      send_entry(5, 6, 16'd2, 1);

      // random phases of well-formed runs with some noise entries
      random_base = queued_items;
      phase = 0;
      while (queued_items - random_base < RANDOM_TARGET) begin
         if (queued_items - random_base >= RANDOM_TARGET - 40)
            steady_flow = 1'b1;
         if (phase == 2)
            count_val = 16;
         else begin
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: count_val = $urandom_range(2, 8);
               7, 8:                count_val = $urandom_range(9, 32);
               default: begin
                  case ($urandom_range(0, 4))
                     0:       count_val = 0;
                     1:       count_val = 1;
                     2:       count_val = $urandom_range(33, 63);
                     3:       count_val = 64;
                     default: count_val = 127;
                  endcase
               end
            endcase
         end
         write_node_count(count_val);
         span = (count_val < 2) ? 2 : ((count_val > MAX_NODES) ? MAX_NODES : count_val);
         // result side blocks long enough for the input to back up
         if (phase == 2)
            hold_request = 1'b1;
         runs = (phase == 2) ? 3 : $urandom_range(1, 3);
         for (int run = 0; run < runs; run++) begin
            // cut one node off from every source so it stays unreached unless a later entry links it
            if (span <= 8 && $urandom_range(0, 3) == 0) begin
               cut_node = $urandom_range(1, span - 1);
               for (int r = 0; r < span; r++)
                  send_entry(r, cut_node, 16'h0000, 0);
            end
            items = $urandom_range(2, 14);
            for (int i = 0; i < items; i++) begin
               if ($urandom_range(0, 7) == 0)
                  send_entry($urandom_range(0, 63), $urandom_range(0, 63), random_weight(),
                             i == items - 1);
               else
                  send_entry($urandom_range(0, span - 1), $urandom_range(0, span - 1),
                             random_weight(), i == items - 1);
            end
         end
         phase++;
      end

      wait_idle();
      $display("covered %0d tree runs (%0d below two nodes), %0d edges checked, %0d unreached",
               run_count, empty_runs, edges_checked, unreached_edges);
      $display("%0d matrix writes with %0d outside the built size, long result stall included",
               queued_items, ignored_writes);
      if (error_count == 0)
         $display("tb_prim_mst_dense_matrix: clean");
      else
         $display("tb_prim_mst_dense_matrix: errors");
      $finish;
   end

endmodule

// ----- prim_mst_dense_matrix.f -----
rtl/pmst_pkg.sv
rtl/pmst_scan.sv
rtl/prim_mst_dense_matrix.sv
verif/tb_prim_mst_dense_matrix.sv
